>>> hdl/tsw_pkg.sv
// Shared constants, types and helpers for the text screen writer.
// Depends on nothing; every other file of the block imports it.

package tsw_pkg;

	localparam int COLUMNS = 64;
	localparam int ROWS    = 16;
	localparam int CELLS   = ROWS * COLUMNS;

	localparam int COL_W  = $clog2(COLUMNS + 1);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int ADDR_W = $clog2(CELLS);
	localparam int POS_W  = $clog2(CELLS + 1);

	localparam logic [7:0] NEWLINE_CODE = 8'd10;
	localparam logic [7:0] BLANK_RESET  = 8'h20;

	typedef enum logic [2:0] {
		REQ_CHAR        = 3'd0,
		REQ_BEGIN_POS   = 3'd1,
		REQ_BEGIN_SAVED = 3'd2,
		REQ_END         = 3'd3,
		REQ_READ        = 3'd4,
		REQ_CLEAR       = 3'd5
	} req_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;
		logic exec;
		logic ptr_clr;
		logic ptr_inc;
		logic rd_cell;
		logic rd_copy;
		logic wr_copy;
		logic wr_blank;
		logic wr_char_late;
		logic load_out;
	} tsw_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_scroll;
		logic is_read;
		logic is_clear;
		logic char_pending;
		logic copy_last;
		logic fill_last;
		logic out_free;
	} tsw_sts_t;

	// Cell offset of a screen position, row major.
	function automatic logic [POS_W-1:0] cell_pos(input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col);
		return POS_W'(int'(row) * COLUMNS + int'(col));
	endfunction

endpackage

>>> hdl/tsw_ctrl.sv
// Sequencer of the text screen writer: request dispatch, scroll and fill sweeps.
// Depends on tsw_pkg for the command and status structs.

module tsw_ctrl import tsw_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  tsw_sts_t sts,
	output tsw_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_RD_WAIT,
		S_SCR_RD,
		S_SCR_WR,
		S_FILL,
		S_CHAR_WR,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				if (sts.need_scroll) begin
					cmd.ptr_clr = 1'b1;
					state_d     = S_SCR_RD;
				end else if (sts.is_read) begin
					cmd.rd_cell = 1'b1;
					state_d     = S_RD_WAIT;
				end else if (sts.is_clear) begin
					cmd.ptr_clr = 1'b1;
					state_d     = S_FILL;
				end else if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SCR_RD: begin
				cmd.rd_copy = 1'b1;
				state_d     = S_SCR_WR;
			end
			S_SCR_WR: begin
				cmd.wr_copy = 1'b1;
				cmd.ptr_inc = 1'b1;
				state_d     = sts.copy_last ? S_FILL : S_SCR_RD;
			end
			S_FILL: begin
				cmd.wr_blank = 1'b1;
				cmd.ptr_inc  = 1'b1;
				if (sts.fill_last) begin
					if (sts.char_pending) begin
						state_d = S_CHAR_WR;
					end else if (sts.out_free) begin
						cmd.load_out = 1'b1;
						state_d      = S_IDLE;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_CHAR_WR: begin
				cmd.wr_char_late = 1'b1;
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end else begin
					state_d = S_DONE;
				end
			end
			S_RD_WAIT, S_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end else begin
					state_d = S_DONE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> hdl/tsw_datapath.sv
// Datapath of the text screen writer: screen store, positions, sweep pointer,
// request latch and result register. Depends on tsw_pkg.

module tsw_datapath import tsw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  tsw_cmd_t    cmd,
	output tsw_sts_t    sts,
	input  logic [2:0]  req_type,
	input  logic [7:0]  char_code,
	input  logic [6:0]  start_col,
	input  logic [4:0]  start_row,
	input  logic        update_cursor,
	input  logic [9:0]  cell_index,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  read_data,
	output logic [6:0]  cur_col,
	output logic [3:0]  cur_row,
	output logic [10:0] saved_pos,
	output logic        scrolled
);

	logic [7:0] mem [CELLS];

	// request latch
	logic [2:0] req_q;
	logic [7:0] char_q;
	logic [6:0] scol_q;
	logic [4:0] srow_q;
	logic       upd_q;
	logic [9:0] idx_q;

	// state
	logic [COL_W-1:0]  work_col_q, work_col_d;
	logic [ROW_W-1:0]  work_row_q, work_row_d;
	logic [COL_W-1:0]  saved_col_q, saved_col_d;
	logic [ROW_W-1:0]  saved_row_q, saved_row_d;
	logic [POS_W-1:0]  saved_pos_q, saved_pos_d;
	logic              commit_q, commit_d;
	logic              scr_q, scr_d;
	logic [7:0]        blank_q;
	logic [ADDR_W-1:0] ptr_q;
	logic [7:0]        rdata_q;
	logic              out_valid_q;

	// request step
	logic [COL_W-1:0] ex_col;
	logic [ROW_W:0]   ex_row_t;
	logic [ROW_W-1:0] ex_row;
	logic             ex_commit;
	logic             ex_wr;
	logic             need_scroll;
	logic [ROW_W:0]   row_inc;
	logic             rd_hit;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [7:0]        mem_wdata;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;

	assign row_inc = {1'b0, work_row_q} + (ROW_W+1)'(1);

	always_comb begin
		ex_col    = work_col_q;
		ex_row_t  = {1'b0, work_row_q};
		ex_commit = commit_q;
		ex_wr     = 1'b0;
		case (req_t'(req_q))
			REQ_CHAR: begin
				if (char_q == NEWLINE_CODE) begin
					ex_col   = '0;
					ex_row_t = row_inc;
				end else begin
					if (int'(work_col_q) >= COLUMNS) begin
						ex_col   = '0;
						ex_row_t = row_inc;
					end
					ex_wr = 1'b1;
				end
			end
			REQ_BEGIN_POS: begin
				ex_col    = (int'(scol_q) > COLUMNS) ? COL_W'(COLUMNS) : COL_W'(scol_q);
				ex_row_t  = (int'(srow_q) > ROWS) ? (ROW_W+1)'(ROWS) : (ROW_W+1)'(srow_q);
				ex_commit = upd_q;
			end
			REQ_BEGIN_SAVED: begin
				// a saved column at the right edge is the start of the next row
				if (saved_col_q == COL_W'(COLUMNS)) begin
					ex_col   = '0;
					ex_row_t = {1'b0, saved_row_q} + (ROW_W+1)'(1);
				end else begin
					ex_col   = saved_col_q;
					ex_row_t = {1'b0, saved_row_q};
				end
				ex_commit = 1'b1;
			end
			default: begin
			end
		endcase
		need_scroll = (int'(ex_row_t) >= ROWS);
		ex_row      = need_scroll ? ROW_W'(ROWS - 1) : ex_row_t[ROW_W-1:0];
	end

	assign rd_hit = (req_t'(req_q) == REQ_READ) && (int'(idx_q) < CELLS);

	assign sts.need_scroll  = need_scroll;
	assign sts.is_read      = (req_t'(req_q) == REQ_READ);
	assign sts.is_clear     = (req_t'(req_q) == REQ_CLEAR);
	assign sts.char_pending = (req_t'(req_q) == REQ_CHAR) && (char_q != NEWLINE_CODE);
	assign sts.copy_last    = (ptr_q == ADDR_W'(CELLS - COLUMNS - 1));
	assign sts.fill_last    = (ptr_q == ADDR_W'(CELLS - 1));
	assign sts.out_free     = !out_valid_q || out_ready;

	// next state of the position registers
	always_comb begin
		work_col_d  = work_col_q;
		work_row_d  = work_row_q;
		saved_col_d = saved_col_q;
		saved_row_d = saved_row_q;
		saved_pos_d = saved_pos_q;
		commit_d    = commit_q;
		scr_d       = scr_q;
		if (cmd.exec) begin
			scr_d = need_scroll;
			case (req_t'(req_q))
				REQ_CHAR, REQ_BEGIN_POS, REQ_BEGIN_SAVED: begin
					work_col_d = (ex_wr && !need_scroll) ? ex_col + COL_W'(1) : ex_col;
					work_row_d = ex_row;
					commit_d   = ex_commit;
				end
				REQ_END: begin
					if (commit_q) begin
						saved_col_d = work_col_q;
						saved_row_d = work_row_q;
						saved_pos_d = cell_pos(work_row_q, work_col_q);
					end
					commit_d = 1'b0;
				end
				REQ_CLEAR: begin
					saved_col_d = '0;
					saved_row_d = '0;
					saved_pos_d = '0;
				end
				default: begin
				end
			endcase
		end
		if (cmd.wr_char_late) begin
			work_col_d = work_col_q + COL_W'(1);
		end
	end

	// store port selection
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ptr_q;
		mem_wdata = blank_q;
		if (cmd.exec && ex_wr && !need_scroll) begin
			mem_we    = 1'b1;
			mem_waddr = ADDR_W'(cell_pos(ex_row, ex_col));
			mem_wdata = char_q;
		end else if (cmd.wr_char_late) begin
			mem_we    = 1'b1;
			mem_waddr = ADDR_W'(cell_pos(work_row_q, work_col_q));
			mem_wdata = char_q;
		end else if (cmd.wr_copy) begin
			mem_we    = 1'b1;
			mem_wdata = rdata_q;
		end else if (cmd.wr_blank) begin
			mem_we = 1'b1;
		end
		mem_re    = cmd.rd_copy || (cmd.rd_cell && rd_hit);
		mem_raddr = cmd.rd_cell ? ADDR_W'(idx_q) : ptr_q + ADDR_W'(COLUMNS);
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q  <= req_type;
			char_q <= char_code;
			scol_q <= start_col;
			srow_q <= start_row;
			upd_q  <= update_cursor;
			idx_q  <= cell_index;
		end
		if (cmd.ptr_clr) begin
			ptr_q <= '0;
		end else if (cmd.ptr_inc) begin
			ptr_q <= ptr_q + ADDR_W'(1);
		end
		if (cmd.load_out) begin
			read_data <= rd_hit ? rdata_q : 8'd0;
			cur_col   <= 7'(work_col_d);
			cur_row   <= 4'(work_row_d);
			saved_pos <= 11'(saved_pos_d);
			scrolled  <= scr_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_col_q  <= '0;
			work_row_q  <= '0;
			saved_col_q <= '0;
			saved_row_q <= '0;
			saved_pos_q <= '0;
			commit_q    <= 1'b0;
			scr_q       <= 1'b0;
			blank_q     <= BLANK_RESET;
			out_valid_q <= 1'b0;
		end else begin
			work_col_q  <= work_col_d;
			work_row_q  <= work_row_d;
			saved_col_q <= saved_col_d;
			saved_row_q <= saved_row_d;
			saved_pos_q <= saved_pos_d;
			commit_q    <= commit_d;
			scr_q       <= scr_d;
			if (cfg_we) begin
				blank_q <= cfg_wdata;
			end
			out_valid_q <= cmd.load_out || (out_valid_q && !out_ready);
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> hdl/text_screen_writer_with_scroll_unit.sv
// Top level of the text screen writer with scroll.
// Depends on tsw_pkg, tsw_ctrl and tsw_datapath.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  in       | in_valid / in_ready  | req_type char_code start_col start_row
//           |                      | update_cursor cell_index
//  out      | out_valid/ out_ready | read_data cur_col cur_row saved_pos scrolled
//  cfg      | cfg_we (no wait)     | cfg_wdata (blank code)
//
// A request is latched on acceptance and executed; then its item sits in the
// result register: character, begin, end and unused codes; a read adds a wait
// step for the registered store read port. A scroll walks the store through its
// single read and write port, a read and a write step per moved cell, then fill
// steps for the bottom row and any late character write; a clear blanks all.
// Reset clears positions, the saved cursor and the blank code to 0x20; the
// store keeps no reset and must be cleared before it is read.
// The next item is accepted while the last result waits; a stalled output
// holds the controller in its final step until the result register drains.

module text_screen_writer_with_scroll_unit import tsw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  req_type,
	input  logic [7:0]  char_code,
	input  logic [6:0]  start_col,
	input  logic [4:0]  start_row,
	input  logic        update_cursor,
	input  logic [9:0]  cell_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  read_data,
	output logic [6:0]  cur_col,
	output logic [3:0]  cur_row,
	output logic [10:0] saved_pos,
	output logic        scrolled,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata
);

	tsw_cmd_t cmd;
	tsw_sts_t sts;

	// sequencing: dispatch, sweeps, result hand-off
	tsw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// store, positions and result register
	tsw_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.req_type      (req_type),
		.char_code     (char_code),
		.start_col     (start_col),
		.start_row     (start_row),
		.update_cursor (update_cursor),
		.cell_index    (cell_index),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.read_data     (read_data),
		.cur_col       (cur_col),
		.cur_row       (cur_row),
		.saved_pos     (saved_pos),
		.scrolled      (scrolled)
	);

endmodule

>>> hdl/tsw_checker.sv
// Port-level checks for the text screen writer, bound to its top level.
// Depends on tsw_pkg for the screen dimensions.

module tsw_checker import tsw_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [2:0]  req_type,
	input logic [7:0]  char_code,
	input logic [6:0]  start_col,
	input logic [4:0]  start_row,
	input logic        update_cursor,
	input logic [9:0]  cell_index,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  read_data,
	input logic [6:0]  cur_col,
	input logic [3:0]  cur_row,
	input logic [10:0] saved_pos,
	input logic        scrolled,
	input logic        cfg_we,
	input logic [7:0]  cfg_wdata
);

	// one item at a time: no second acceptance right after the first
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted twice in a row");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(cur_col) && $stable(cur_row)
			&& $stable(saved_pos) && $stable(scrolled) && $stable(read_data)))
		else $error("stalled result changed");

	// a scroll always leaves the working row on the bottom line
	a_scroll_row: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && scrolled) |-> (int'(cur_row) == ((ROWS - 1) % 16)))
		else $error("scroll left working row off the bottom line");

	// the working column never passes the right edge
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (int'(cur_col) <= COLUMNS))
		else $error("working column out of range");

endmodule

bind text_screen_writer_with_scroll_unit tsw_checker u_tsw_checker (.*);
